>>> sv/psvs_pkg.sv
// Package for the polyphonic sine voice synthesizer: sizes, command codes,
// item structs and the constant sine, fade and pitch step tables.
// No dependencies.
`default_nettype none
package psvs_pkg;

    localparam int VOICES       = 16;
    localparam int VIDX_W       = $clog2(VOICES);
    localparam int SEMITONES    = 88;
    localparam int PHASE_BITS   = 32;
    localparam int SAMPLE_RATE  = 48000;
    localparam int FADE_ENTRIES = 256;
    localparam int FADE_SECONDS = 4;
    localparam int ELAPSED_W    = 18;
    localparam int FT_W         = 12;
    localparam int CNT_W        = 5;
    localparam int SMP_W        = 24;
    localparam int MAG_W        = 23;
    localparam int ACC_W        = 60;
    localparam int NUM_W        = ACC_W + 1;
    localparam int Q23_MAX      = 8388607;

    // fade index = floor(elapsed * FADE_ENTRIES / (FADE_SECONDS * SAMPLE_RATE))
    localparam longint FADE_DEN   = FADE_SECONDS * SAMPLE_RATE;
    localparam int     FADE_SHIFT = 30;
    localparam longint FADE_MUL   =
        ((64'd1 << FADE_SHIFT) * FADE_ENTRIES + FADE_DEN - 1) / FADE_DEN;
    localparam int     FMUL_W     = $clog2(FADE_MUL + 1);
    localparam int     FPROD_W    = ELAPSED_W + FMUL_W;
    localparam int     FIDX_W     = FPROD_W - FADE_SHIFT;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] semitone;
        logic [7:0] force_req;
        logic [3:0] slot;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [3:0]              slot_used;
        logic                    rejected;
        logic [CNT_W-1:0]        active_count;
    } t_out;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
    } t_mac_ctl;

    typedef logic [MAG_W-1:0]      t_sine_tab [0:256];
    typedef logic [MAG_W-1:0]      t_fade_tab [0:FADE_ENTRIES-1];
    typedef logic [PHASE_BITS-1:0] t_step_tab [0:SEMITONES-1];

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned LN2_Q30     = 64'd744261118;

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab      t;
        longint unsigned x, x2, b, v;
        for (int i = 0; i <= 256; i++) begin
            x  = (longint'(i) * HALF_PI_Q30 + 128) >> 8;
            x2 = q30_mul(x, x);
            b  = Q30_ONE;
            b  = Q30_ONE - q30_mul(x2, b) / 110;
            b  = Q30_ONE - q30_mul(x2, b) / 72;
            b  = Q30_ONE - q30_mul(x2, b) / 42;
            b  = Q30_ONE - q30_mul(x2, b) / 20;
            b  = Q30_ONE - q30_mul(x2, b) / 6;
            v  = (q30_mul(x, b) + 64) >> 7;
            if (v > Q23_MAX) v = Q23_MAX;
            t[i] = v[MAG_W-1:0];
        end
        return t;
    endfunction

    function automatic t_fade_tab build_fade();
        t_fade_tab       t;
        longint unsigned num, u, n, r, b, v, sh;
        for (int i = 0; i < FADE_ENTRIES; i++) begin
            num = (longint'(FADE_SECONDS * FADE_SECONDS) * i * i) << 30;
            u   = (num + (FADE_ENTRIES * FADE_ENTRIES) / 2) / (FADE_ENTRIES * FADE_ENTRIES);
            n   = u / LN2_Q30;
            r   = u - n * LN2_Q30;
            b   = Q30_ONE;
            b   = Q30_ONE - q30_mul(r, b) / 10;
            b   = Q30_ONE - q30_mul(r, b) / 9;
            b   = Q30_ONE - q30_mul(r, b) / 8;
            b   = Q30_ONE - q30_mul(r, b) / 7;
            b   = Q30_ONE - q30_mul(r, b) / 6;
            b   = Q30_ONE - q30_mul(r, b) / 5;
            b   = Q30_ONE - q30_mul(r, b) / 4;
            b   = Q30_ONE - q30_mul(r, b) / 3;
            b   = Q30_ONE - q30_mul(r, b) / 2;
            b   = Q30_ONE - q30_mul(r, b) / 1;
            if (n + 7 >= 40) begin
                v = 0;
            end else begin
                sh = n + 7;
                v  = (b + (64'd1 << (sh - 1))) >> sh;
            end
            if (v > Q23_MAX) v = Q23_MAX;
            t[i] = v[MAG_W-1:0];
        end
        return t;
    endfunction

    function automatic longint unsigned semi_ratio(int k);
        case (k)
            0: return 65536;   1: return 69433;   2: return 73562;
            3: return 77936;   4: return 82570;   5: return 87480;
            6: return 92682;   7: return 98193;   8: return 104032;
            9: return 110218;  10: return 116772; default: return 123715;
        endcase
    endfunction

    function automatic t_step_tab build_step();
        t_step_tab       t;
        longint unsigned num, s;
        for (int i = 0; i < SEMITONES; i++) begin
            num  = (64'd55 * semi_ratio(i % 12)) << (i / 12 + PHASE_BITS - 17);
            s    = (num + SAMPLE_RATE / 2) / SAMPLE_RATE;
            t[i] = s[PHASE_BITS-1:0];
        end
        return t;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();
    localparam t_fade_tab FADE_TAB = build_fade();
    localparam t_step_tab STEP_TAB = build_step();

endpackage
`default_nettype wire

>>> sv/psvs_mac.sv
// Voice multiply-accumulate: fade times sine, then times force, summed.
// Depends on psvs_pkg.
`default_nettype none
module psvs_mac (
    input  wire logic                          i_clk,
    input  wire psvs_pkg::t_mac_ctl            i_ctl,
    input  wire logic signed [psvs_pkg::SMP_W-1:0] i_sine,
    input  wire logic [psvs_pkg::MAG_W-1:0]    i_fade,
    input  wire logic [7:0]                    i_force,
    output logic signed [psvs_pkg::ACC_W-1:0]  o_acc
);
    logic signed [2*psvs_pkg::SMP_W-1:0]      r_prod;
    logic signed [psvs_pkg::ACC_W-1:0]        r_acc;
    logic signed [2*psvs_pkg::SMP_W+8:0]      w_wprod;

    assign w_wprod = $signed({1'b0, i_force}) * r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= $signed({1'b0, i_fade}) * i_sine;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + psvs_pkg::ACC_W'(w_wprod);
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

>>> sv/psvs_div.sv
// Restoring divider, one quotient bit per cycle, saturated to Q1.23 magnitude.
// Depends on psvs_pkg.
`default_nettype none
module psvs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [psvs_pkg::NUM_W-1:0]    i_num,
    input  wire logic [psvs_pkg::FT_W-1:0]     i_ft,
    output logic                               o_done,
    output logic [psvs_pkg::MAG_W-1:0]         o_quot
);
    localparam int DV_W = psvs_pkg::FT_W + 2 * psvs_pkg::MAG_W;
    localparam int Q_W  = psvs_pkg::MAG_W + 1;

    logic [psvs_pkg::NUM_W-1:0] r_rem;
    logic [DV_W-1:0]            r_dv;
    logic [Q_W-1:0]             r_q;
    logic [$clog2(Q_W)-1:0]     r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [psvs_pkg::NUM_W-1:0] w_dv;

    assign w_dv = psvs_pkg::NUM_W'(r_dv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ($clog2(Q_W))'(Q_W - 1);
                r_rem  <= i_num;
                r_dv   <= {i_ft, {(2 * psvs_pkg::MAG_W){1'b0}}};
                r_q    <= '0;
            end else if (r_busy) begin
                if (r_rem >= w_dv) begin
                    r_rem <= r_rem - w_dv;
                    r_q   <= {r_q[Q_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[Q_W-2:0], 1'b0};
                end
                r_dv <= r_dv >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_q > Q_W'(psvs_pkg::Q23_MAX)) ? psvs_pkg::MAG_W'(psvs_pkg::Q23_MAX)
                                                     : r_q[psvs_pkg::MAG_W-1:0];

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy)
        else $error("divider did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done)
        else $error("divider done longer than one cycle");
endmodule
`default_nettype wire

>>> sv/polyphonic_sine_voice_synth.sv
// Top level of the polyphonic sine voice synthesizer: command sequencer,
// voice registers and output register. Uses psvs_pkg, psvs_mac, psvs_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one command item:
//   sample tick, note on, note off or no operation. Output channel
//   (o_out_valid / i_out_ready / o_out) returns exactly one result item per
//   command. An item is taken only while the sequencer is idle.
//   Command sequence:
//     note on : scans from slot 0 up to the lowest free slot
//     note off: straight to the result when rejected, else via release
//     no op   : straight to the result
//     tick    : lookup, multiply and accumulate for each active voice and
//               a skip for each inactive one, then the restoring divider
//               (skipped when the force total is zero) and the output
//               register. The shared multiply-accumulate unit visits
//               the voices one by one, and the divider produces one
//               quotient bit per cycle.
//   Reset (synchronous, active low) clears all voice active flags, the force
//   total and the voice count; voice pitch, force, phase and age registers
//   are written at note on and need no reset.
//   A stalled receiver holds the result in the output register; the next
//   command is still taken and processed, and its result waits until the
//   output register drains.
`default_nettype none
module polyphonic_sine_voice_synth (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire psvs_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output psvs_pkg::t_out      o_out
);
    localparam int V  = psvs_pkg::VOICES;
    localparam int VW = psvs_pkg::VIDX_W;
    localparam logic [VW-1:0] LAST = VW'(V - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_OFF   = 4'd2;
    localparam logic [3:0] S_TA    = 4'd3;
    localparam logic [3:0] S_TB    = 4'd4;
    localparam logic [3:0] S_TC    = 4'd5;
    localparam logic [3:0] S_DIVST = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // control state
    logic [3:0]                   r_state;
    logic [VW-1:0]                r_idx;
    logic [V-1:0]                 r_active;
    logic [psvs_pkg::FT_W-1:0]    r_ft;
    logic [psvs_pkg::CNT_W-1:0]   r_count;
    logic                         r_out_valid;
    psvs_pkg::t_out               r_out;
    psvs_pkg::t_out               r_res;
    psvs_pkg::t_in                r_cmd;

    // voice store, written at note on and on ticks
    logic [6:0]                        r_semi    [V];
    logic [7:0]                        r_force   [V];
    logic [psvs_pkg::PHASE_BITS-1:0]   r_phase   [V];
    logic [psvs_pkg::ELAPSED_W-1:0]    r_elapsed [V];

    // per-voice tick datapath
    logic [psvs_pkg::FPROD_W-1:0]      r_fprod;
    logic signed [psvs_pkg::SMP_W-1:0] r_sine;
    logic                              r_neg;

    logic [psvs_pkg::PHASE_BITS-1:0]   w_ph;
    logic [9:0]                        w_top;
    logic [8:0]                        w_j;
    logic [psvs_pkg::MAG_W-1:0]        w_smag;
    logic signed [psvs_pkg::SMP_W-1:0] w_sine;
    logic [psvs_pkg::FIDX_W-1:0]       w_fi;
    logic [psvs_pkg::MAG_W-1:0]        w_fade;
    logic [6:0]                        w_semi;

    psvs_pkg::t_mac_ctl                w_mac;
    logic signed [psvs_pkg::ACC_W-1:0] w_acc;
    logic [psvs_pkg::ACC_W-1:0]        w_mag;
    logic [psvs_pkg::NUM_W-1:0]        w_num;
    logic                              w_div_start;
    logic                              w_div_done;
    logic [psvs_pkg::MAG_W-1:0]        w_quot;
    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_off_rej;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // note off on a free slot is refused right away
    assign w_off_rej = (i_in.cmd == psvs_pkg::CMD_OFF) && !r_active[i_in.slot[VW-1:0]];

    // sine lookup: quadrant from the top two phase bits, mirror odd quadrants
    assign w_ph   = r_phase[r_idx];
    assign w_top  = w_ph[psvs_pkg::PHASE_BITS-1 -: 10];
    assign w_j    = w_top[8] ? (9'd256 - {1'b0, w_top[7:0]}) : {1'b0, w_top[7:0]};
    assign w_smag = psvs_pkg::SINE_TAB[w_j];
    assign w_sine = w_top[9] ? -$signed({1'b0, w_smag}) : $signed({1'b0, w_smag});

    // fade lookup, zero past the end of the table
    assign w_fi   = r_fprod[psvs_pkg::FPROD_W-1:psvs_pkg::FADE_SHIFT];
    assign w_fade = (w_fi < psvs_pkg::FIDX_W'(psvs_pkg::FADE_ENTRIES))
                    ? psvs_pkg::FADE_TAB[w_fi[$clog2(psvs_pkg::FADE_ENTRIES)-1:0]] : '0;

    assign w_semi = (r_cmd.semitone > 7'(psvs_pkg::SEMITONES - 1))
                    ? 7'(psvs_pkg::SEMITONES - 1) : r_cmd.semitone;

    assign w_mac.clr = w_in_acc && (i_in.cmd == psvs_pkg::CMD_TICK);
    assign w_mac.mul = (r_state == S_TB);
    assign w_mac.acc = (r_state == S_TC);

    // rounded magnitude numerator: |acc| + half of force_total * 2^23
    assign w_mag = w_acc[psvs_pkg::ACC_W-1] ? psvs_pkg::ACC_W'(-w_acc) : psvs_pkg::ACC_W'(w_acc);
    assign w_num = {1'b0, w_mag} + psvs_pkg::NUM_W'({r_ft, {(psvs_pkg::MAG_W-1){1'b0}}});
    assign w_div_start = (r_state == S_DIVST) && (r_ft != '0);

    psvs_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_mac),
        .i_sine  (r_sine),
        .i_fade  (w_fade),
        .i_force (r_force[r_idx]),
        .o_acc   (w_acc)
    );

    psvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_ft    (r_ft),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // voice store writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIND && !r_active[r_idx]) begin
            r_semi[r_idx]    <= w_semi;
            r_force[r_idx]   <= r_cmd.force_req;
            r_phase[r_idx]   <= '0;
            r_elapsed[r_idx] <= '0;
        end else if (r_state == S_TC) begin
            // advance phase, age saturates
            r_phase[r_idx] <= r_phase[r_idx] + psvs_pkg::STEP_TAB[r_semi[r_idx]];
            if (r_elapsed[r_idx] != '1) begin
                r_elapsed[r_idx] <= r_elapsed[r_idx] + 1'b1;
            end
        end
        if (r_state == S_TA) begin
            r_fprod <= psvs_pkg::FPROD_W'(r_elapsed[r_idx] * psvs_pkg::FMUL_W'(psvs_pkg::FADE_MUL));
            r_sine  <= w_sine;
        end
        if (r_state == S_DIVST) begin
            r_neg <= w_acc[psvs_pkg::ACC_W-1];
        end
        if (w_in_acc) begin
            r_cmd <= i_in;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_active    <= '0;
            r_ft        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load on a free output register, drop once taken
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_res <= '{sample: '0, slot_used: '0, rejected: w_off_rej,
                                   active_count: '0};
                        r_idx <= (i_in.cmd == psvs_pkg::CMD_OFF) ? i_in.slot[VW-1:0] : '0;
                        unique case (i_in.cmd)
                            psvs_pkg::CMD_TICK: r_state <= S_TA;
                            psvs_pkg::CMD_ON:   r_state <= S_FIND;
                            psvs_pkg::CMD_OFF:  r_state <= w_off_rej ? S_DONE : S_OFF;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FIND: begin
                    if (!r_active[r_idx]) begin
                        r_active[r_idx] <= 1'b1;
                        r_ft            <= r_ft + psvs_pkg::FT_W'(r_cmd.force_req);
                        r_count         <= r_count + 1'b1;
                        r_res.slot_used <= 4'(r_idx);
                        r_state         <= S_DONE;
                    end else if (r_idx == LAST) begin
                        r_res.rejected <= 1'b1;
                        r_state        <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OFF: begin
                    r_active[r_idx] <= 1'b0;
                    r_ft            <= r_ft - psvs_pkg::FT_W'(r_force[r_idx]);
                    r_count         <= r_count - 1'b1;
                    r_state         <= S_DONE;
                end
                S_TA: begin
                    // skip silent slots without the multiply and accumulate states
                    if (r_active[r_idx]) begin
                        r_state <= S_TB;
                    end else if (r_idx == LAST) begin
                        r_state <= S_DIVST;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TB: r_state <= S_TC;
                S_TC: begin
                    if (r_idx == LAST) begin
                        r_state <= S_DIVST;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_TA;
                    end
                end
                S_DIVST: begin
                    // zero force total gives a silent sample
                    r_state <= (r_ft == '0) ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res.sample <= r_neg ? -$signed({1'b0, w_quot})
                                              : $signed({1'b0, w_quot});
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out   <= '{sample: r_res.sample, slot_used: r_res.slot_used,
                                     rejected: r_res.rejected, active_count: r_count};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == psvs_pkg::CNT_W'($countones(r_active)))
        else $error("voice count disagrees with active flags");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_ft == '0))
        else $error("force total nonzero with no voices");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("item accepted but sequencer stayed idle");
endmodule
`default_nettype wire
